// ===== hw/rtl/modal_key_command_parser_defines.svh =====
// Assertion macros used by the parser top level.
`ifndef MODAL_KEY_COMMAND_PARSER_DEFINES_SVH
`define MODAL_KEY_COMMAND_PARSER_DEFINES_SVH

// Checked on every edge, reset included.
`define MKCP_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("parser check failed");

// Checked on every edge, reset included, same cycle.
`define MKCP_ASSERT_IMPL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("parser check failed");

`endif

// ===== hw/rtl/mkcp_pkg.sv =====
package mkcp_pkg;

    localparam int KEY_W = 21;
    localparam int CH_W = 7;
    localparam int CNT_W = 16;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int OBUF_DEPTH = 2;
    localparam int OPTR_W = (OBUF_DEPTH > 1) ? $clog2(OBUF_DEPTH) : 1;
    localparam int OCNT_W = $clog2(OBUF_DEPTH + 1);

    localparam logic [CH_W-1:0] CH_DQUOTE = 7'h22;
    localparam logic [CH_W-1:0] CH_SQUOTE = 7'h27;
    localparam logic [CH_W-1:0] CH_ZERO = 7'h30;
    localparam logic [CH_W-1:0] CH_NINE = 7'h39;
    localparam logic [CH_W-1:0] CH_LBRACK = 7'h5B;
    localparam logic [CH_W-1:0] CH_LOW_A = 7'h61;
    localparam logic [CH_W-1:0] CH_LOW_D = 7'h64;
    localparam logic [CH_W-1:0] CH_LOW_G = 7'h67;
    localparam logic [CH_W-1:0] CH_LOW_I = 7'h69;
    localparam logic [CH_W-1:0] CH_LOW_M = 7'h6D;
    localparam logic [CH_W-1:0] CH_LOW_Z = 7'h7A;
    localparam logic [CH_W-1:0] CH_TILDE = 7'h7E;

    typedef enum logic [1:0] {
        KIND_DONE       = 2'd0,
        KIND_ERROR      = 2'd1,
        KIND_INSERTED   = 2'd2,
        KIND_INSERT_END = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_BUF0 = 3'd0,
        ST_BUF1 = 3'd1,
        ST_CMD  = 3'd2,
        ST_DBL  = 3'd3,
        ST_ARG  = 3'd4
    } t_parse_state;

    typedef struct packed {
        logic fl_double;
        logic fl_motion;
        logic fl_arg;
    } t_flags;

    // Key as classified by the front end.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             esc;
        logic             key_hi;
        logic             above_tilde;
        logic             is_digit;
        logic             is_zero;
        logic [3:0]       digit;
        logic             is_lower;
        logic             is_dquote;
        t_flags           flags;
    } t_key_item;

    typedef struct packed {
        t_kind            kind;
        logic [CH_W-1:0]  reg_letter;
        logic [CNT_W-1:0] cmd_count;
        logic [CH_W-1:0]  cmd_char;
        logic [CH_W-1:0]  cmd_arg;
        logic [CNT_W-1:0] mot_count;
        logic [CH_W-1:0]  mot_char;
        logic [CH_W-1:0]  mot_arg;
        logic [KEY_W-1:0] passed_key;
    } t_result;

    function automatic t_flags char_flags(input logic [CH_W-1:0] ch);
        t_flags f;
        f = '0;
        unique case (ch)
            CH_LOW_D:            f.fl_motion = 1'b1;
            CH_LOW_G, CH_LBRACK: f.fl_double = 1'b1;
            CH_LOW_M, CH_SQUOTE: f.fl_arg = 1'b1;
            default:             f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== hw/rtl/mkcp_front.sv =====
module mkcp_front (
    input  logic [mkcp_pkg::KEY_W-1:0] i_key,
    input  logic                       i_is_escape,
    input  logic                       i_push,
    input  logic                       i_q_full,
    output logic                       o_full,
    output logic                       o_q_push,
    output mkcp_pkg::t_key_item        o_q_item
);
    import mkcp_pkg::*;

    logic [CH_W-1:0] key7;
    logic            key_hi;

    assign key7 = i_key[CH_W-1:0];
    assign key_hi = |i_key[KEY_W-1:CH_W];

    always_comb begin
        o_q_item.key = i_key;
        o_q_item.esc = i_is_escape;
        o_q_item.key_hi = key_hi;
        o_q_item.above_tilde = key_hi || (key7 > CH_TILDE);
        o_q_item.is_digit = !key_hi && (key7 >= CH_ZERO) && (key7 <= CH_NINE);
        o_q_item.is_zero = !key_hi && (key7 == CH_ZERO);
        o_q_item.digit = 4'(key7 - CH_ZERO);
        o_q_item.is_lower = !key_hi && (key7 >= CH_LOW_A) && (key7 <= CH_LOW_Z);
        o_q_item.is_dquote = !key_hi && (key7 == CH_DQUOTE);
        o_q_item.flags = char_flags(key7);
    end

    assign o_full = i_q_full;
    assign o_q_push = i_push && !i_q_full;

endmodule

// ===== hw/rtl/mkcp_queue.sv =====
module mkcp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mkcp_pkg::t_key_item i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output mkcp_pkg::t_key_item o_item
);
    import mkcp_pkg::*;

    t_key_item           r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic [QPTR_W-1:0]   n_wr;
    logic [QPTR_W-1:0]   n_rd;
    logic [QCNT_W-1:0]   n_cnt;

    assign o_full = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

// ===== hw/rtl/mkcp_back.sv =====
module mkcp_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_q_empty,
    input  mkcp_pkg::t_key_item        i_q_item,
    output logic                       o_q_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output mkcp_pkg::t_result          o_result
);
    import mkcp_pkg::*;

    typedef struct packed {
        logic             in_motion;
        logic [CH_W-1:0]  reg_letter;
        logic [CNT_W-1:0] cmd_count;
        logic [CH_W-1:0]  cmd_char;
        logic [CH_W-1:0]  cmd_arg;
        logic [CNT_W-1:0] mot_count;
        logic [CH_W-1:0]  mot_char;
        logic [CH_W-1:0]  mot_arg;
    } t_held;

    t_parse_state      r_state;
    t_parse_state      n_state;
    t_parse_state      upd_state;
    logic              r_insert;
    logic              n_insert;
    logic              upd_insert;
    t_held             r_held;
    t_held             n_held;
    t_held             upd_held;

    t_key_item         it;
    logic              take;
    logic              ev_done;
    logic              ev_err;
    logic              ev_ins;
    logic              ev_exit;
    logic              ev_clear;
    logic              cmd_path;
    logic              go_dbl;
    logic              go_arg;
    logic [CH_W-1:0]   dbl_char;
    logic [CH_W-1:0]   cur_char;
    logic [CNT_W-1:0]  cur_cnt;
    logic [CNT_W-1:0]  new_cnt;

    logic              res_valid;
    t_result           res;

    t_result           r_obuf [OBUF_DEPTH];
    logic [OPTR_W-1:0] r_owr;
    logic [OPTR_W-1:0] r_ord;
    logic [OCNT_W-1:0] r_ocnt;
    logic [OPTR_W-1:0] n_owr;
    logic [OPTR_W-1:0] n_ord;
    logic [OCNT_W-1:0] n_ocnt;
    logic              obuf_pop;
    logic              obuf_push;
    logic              obuf_space;

    assign it = i_q_item;
    assign o_empty = (r_ocnt == '0);
    assign o_result = r_obuf[r_ord];
    assign obuf_pop = i_pop && !o_empty;
    // A slot frees up in the same cycle when the head result is popped.
    assign obuf_space = (r_ocnt != OCNT_W'(OBUF_DEPTH)) || obuf_pop;
    assign take = !i_q_empty && obuf_space;
    assign o_q_pop = take;

    assign dbl_char = r_held.in_motion ? r_held.mot_char : r_held.cmd_char;

    // Parser update for one key, before the end-of-command clear.
    always_comb begin
        upd_state = r_state;
        upd_insert = r_insert;
        upd_held = r_held;
        ev_done = 1'b0;
        ev_err = 1'b0;
        ev_ins = 1'b0;
        ev_exit = 1'b0;
        ev_clear = 1'b0;
        cmd_path = 1'b0;
        go_dbl = 1'b0;
        go_arg = 1'b0;
        cur_cnt = '0;
        new_cnt = '0;
        cur_char = '0;
        if (take) begin
            if (r_insert) begin
                if (it.esc) begin
                    upd_insert = 1'b0;
                    ev_exit = 1'b1;
                end else begin
                    ev_ins = 1'b1;
                end
            end else if (it.esc) begin
                ev_clear = 1'b1;
            end else begin
                unique case (r_state)
                    ST_BUF1: begin
                        if (!it.is_lower) begin
                            ev_err = 1'b1;
                        end else begin
                            upd_held.reg_letter = it.key[CH_W-1:0];
                            upd_held.in_motion = 1'b0;
                            upd_state = ST_CMD;
                        end
                    end
                    ST_CMD: cmd_path = 1'b1;
                    ST_DBL: begin
                        if (it.key_hi || (it.key[CH_W-1:0] != dbl_char)) begin
                            ev_err = 1'b1;
                        end else begin
                            go_dbl = 1'b1;
                        end
                    end
                    ST_ARG: begin
                        if (it.key_hi) begin
                            ev_err = 1'b1;
                        end else begin
                            if (r_held.in_motion) begin
                                upd_held.mot_arg = it.key[CH_W-1:0];
                            end else begin
                                upd_held.cmd_arg = it.key[CH_W-1:0];
                            end
                            go_arg = 1'b1;
                        end
                    end
                    default: begin
                        if (it.is_dquote) begin
                            upd_state = ST_BUF1;
                        end else begin
                            upd_state = ST_CMD;
                            upd_held.in_motion = 1'b0;
                            cmd_path = 1'b1;
                        end
                    end
                endcase
            end

            if (cmd_path) begin
                cur_cnt = upd_held.in_motion ? upd_held.mot_count : upd_held.cmd_count;
                new_cnt = {cur_cnt[CNT_W-4:0], 3'b000} + {cur_cnt[CNT_W-2:0], 1'b0}
                        + CNT_W'(it.digit);
                if (it.above_tilde) begin
                    ev_err = 1'b1;
                end else if (it.is_digit && (!it.is_zero || (cur_cnt != '0))) begin
                    if (upd_held.in_motion) begin
                        upd_held.mot_count = new_cnt;
                    end else begin
                        upd_held.cmd_count = new_cnt;
                    end
                end else begin
                    if (upd_held.in_motion) begin
                        upd_held.mot_char = it.key[CH_W-1:0];
                    end else begin
                        upd_held.cmd_char = it.key[CH_W-1:0];
                    end
                    if (it.flags.fl_double) begin
                        upd_state = ST_DBL;
                    end else begin
                        go_dbl = 1'b1;
                    end
                end
            end

            // The character of the record being filled, before any switch to the motion.
            cur_char = upd_held.in_motion ? upd_held.mot_char : upd_held.cmd_char;

            if (go_dbl) begin
                if (char_flags(cur_char).fl_arg) begin
                    upd_state = ST_ARG;
                end else begin
                    go_arg = 1'b1;
                end
            end

            // A command taking a motion goes on to it; anything else ends the command.
            if (go_arg) begin
                if (char_flags(cur_char).fl_motion && !upd_held.in_motion) begin
                    upd_held.in_motion = 1'b1;
                    upd_state = ST_CMD;
                end else begin
                    ev_done = 1'b1;
                    if (upd_held.cmd_char == CH_LOW_I) begin
                        upd_insert = 1'b1;
                    end
                end
            end
        end
    end

    // Next state.
    always_comb begin
        n_insert = upd_insert;
        if (ev_done || ev_err || ev_clear) begin
            n_state = ST_BUF0;
            n_held = '0;
        end else begin
            n_state = upd_state;
            n_held = upd_held;
        end
    end

    // Result of the key.
    always_comb begin
        res = '0;
        res_valid = ev_done || ev_err || ev_ins || ev_exit;
        if (ev_done) begin
            res.kind = KIND_DONE;
            res.reg_letter = upd_held.reg_letter;
            res.cmd_count = upd_held.cmd_count;
            res.cmd_char = upd_held.cmd_char;
            res.cmd_arg = upd_held.cmd_arg;
            res.mot_count = upd_held.mot_count;
            res.mot_char = upd_held.mot_char;
            res.mot_arg = upd_held.mot_arg;
        end else if (ev_err) begin
            res.kind = KIND_ERROR;
        end else if (ev_ins) begin
            res.kind = KIND_INSERTED;
            res.passed_key = it.key;
        end else if (ev_exit) begin
            res.kind = KIND_INSERT_END;
        end
    end

    assign obuf_push = res_valid;

    always_comb begin
        n_owr = r_owr;
        n_ord = r_ord;
        n_ocnt = r_ocnt;
        if (obuf_push) begin
            n_owr = (r_owr == OPTR_W'(OBUF_DEPTH - 1)) ? '0 : r_owr + OPTR_W'(1);
        end
        if (obuf_pop) begin
            n_ord = (r_ord == OPTR_W'(OBUF_DEPTH - 1)) ? '0 : r_ord + OPTR_W'(1);
        end
        if (obuf_push && !obuf_pop) begin
            n_ocnt = r_ocnt + OCNT_W'(1);
        end else if (!obuf_push && obuf_pop) begin
            n_ocnt = r_ocnt - OCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_BUF0;
            r_insert <= 1'b0;
            r_held <= '0;
            r_owr <= '0;
            r_ord <= '0;
            r_ocnt <= '0;
        end else begin
            r_state <= n_state;
            r_insert <= n_insert;
            r_held <= n_held;
            r_owr <= n_owr;
            r_ord <= n_ord;
            r_ocnt <= n_ocnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (obuf_push) begin
            r_obuf[r_owr] <= res;
        end
    end

endmodule

// ===== hw/rtl/modal_key_command_parser.sv =====
// Modal key command parser. Keys go in through a queue-style port (push/full) and
// parse results come out of another (empty/pop). The block takes one key per clock
// cycle for as long as results are drained; an accepted key is written into the key
// queue, the parser takes it once the result buffer has room, and its result, if it
// makes one, is written into that buffer. The rate is set by the parser state register
// in the back end, which updates once per key; a two-entry queue of classified keys
// sits between the front end and the parser, and a two-entry result buffer at the output.
// Escape in command mode and keys that only advance a command give no result.
`include "modal_key_command_parser_defines.svh"

module modal_key_command_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [mkcp_pkg::KEY_W-1:0]  i_key,
    input  logic                        i_is_escape,
    output logic                        empty,
    input  logic                        pop,
    output logic [1:0]                  o_kind,
    output logic [mkcp_pkg::CH_W-1:0]   o_register_letter,
    output logic [mkcp_pkg::CNT_W-1:0]  o_cmd_count,
    output logic [mkcp_pkg::CH_W-1:0]   o_cmd_char,
    output logic [mkcp_pkg::CH_W-1:0]   o_cmd_argument,
    output logic [mkcp_pkg::CNT_W-1:0]  o_motion_count,
    output logic [mkcp_pkg::CH_W-1:0]   o_motion_char,
    output logic [mkcp_pkg::CH_W-1:0]   o_motion_argument,
    output logic [mkcp_pkg::KEY_W-1:0]  o_passed_key
);
    import mkcp_pkg::*;

    logic      q_full;
    logic      q_push;
    logic      q_empty;
    logic      q_pop;
    t_key_item q_in_item;
    t_key_item q_out_item;
    t_result   result;
    logic      shown_done;
    logic      shown_other;
    logic      cmd_blank;

    mkcp_front u_front (
        .i_key       (i_key),
        .i_is_escape (i_is_escape),
        .i_push      (push),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_item    (q_in_item)
    );

    mkcp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out_item)
    );

    mkcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_item  (q_out_item),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_result  (result)
    );

    assign o_kind = result.kind;
    assign o_register_letter = result.reg_letter;
    assign o_cmd_count = result.cmd_count;
    assign o_cmd_char = result.cmd_char;
    assign o_cmd_argument = result.cmd_arg;
    assign o_motion_count = result.mot_count;
    assign o_motion_char = result.mot_char;
    assign o_motion_argument = result.mot_arg;
    assign o_passed_key = result.passed_key;

    assign shown_done = !empty && (o_kind == KIND_DONE);
    assign shown_other = !empty && (o_kind != KIND_DONE);
    assign cmd_blank = (o_cmd_char == '0) && (o_register_letter == '0);

    `MKCP_ASSERT_NEXT(a_reset_empties, i_clk, !i_rst_n, empty)
    `MKCP_ASSERT_IMPL(a_pop_needs_item, i_clk, q_pop, !q_empty)
    `MKCP_ASSERT_IMPL(a_done_no_passed_key, i_clk, shown_done, o_passed_key == '0)
    `MKCP_ASSERT_IMPL(a_other_kinds_no_cmd, i_clk, shown_other, cmd_blank)

endmodule

// ===== tb/sv/parse_scoreboard_pkg.sv =====
package parse_scoreboard_pkg;

    import mkcp_pkg::*;

    class parse_scoreboard;

        // Parser state as the block should hold it.
        logic             insert_on;
        t_parse_state     stage;
        logic             on_motion;
        logic [CH_W-1:0]  reg_name;
        logic [CNT_W-1:0] cmd_rep;
        logic [CH_W-1:0]  cmd_ch;
        logic [CH_W-1:0]  cmd_arg_ch;
        logic [CNT_W-1:0] mot_rep;
        logic [CH_W-1:0]  mot_ch;
        logic [CH_W-1:0]  mot_arg_ch;

        t_result          pending_results[$];
        int unsigned      mismatches;

        function new();
            insert_on = 1'b0;
            mismatches = 0;
            clear_command();
        endfunction

        function void clear_command();
            stage = ST_BUF0;
            on_motion = 1'b0;
            reg_name = '0;
            cmd_rep = '0;
            cmd_ch = '0;
            cmd_arg_ch = '0;
            mot_rep = '0;
            mot_ch = '0;
            mot_arg_ch = '0;
        endfunction

        function void flag_error();
            t_result r;
            r = '0;
            r.kind = KIND_ERROR;
            pending_results.push_back(r);
            clear_command();
        endfunction

        function logic [CH_W-1:0] active_char();
            return on_motion ? mot_ch : cmd_ch;
        endfunction

        // A delete that has its own character done goes on to parse a motion;
        // anything else, a motion that wants a motion too, is complete here.
        function void finish_argument();
            t_result r;
            if (!on_motion && cmd_ch == CH_LOW_D) begin
                on_motion = 1'b1;
                stage = ST_CMD;
                return;
            end
            r = '0;
            r.kind = KIND_DONE;
            r.reg_letter = reg_name;
            r.cmd_count = cmd_rep;
            r.cmd_char = cmd_ch;
            r.cmd_arg = cmd_arg_ch;
            r.mot_count = mot_rep;
            r.mot_char = mot_ch;
            r.mot_arg = mot_arg_ch;
            pending_results.push_back(r);
            if (cmd_ch == CH_LOW_I) begin
                insert_on = 1'b1;
            end
            clear_command();
        endfunction

        function void finish_double();
            logic [CH_W-1:0] ch;
            ch = active_char();
            if (ch == CH_LOW_M || ch == CH_SQUOTE) begin
                stage = ST_ARG;
            end else begin
                finish_argument();
            end
        endfunction

        function void take_command(logic [KEY_W-1:0] key);
            logic [CNT_W-1:0] cnt;
            if (key > CH_TILDE) begin
                flag_error();
                return;
            end
            cnt = on_motion ? mot_rep : cmd_rep;
            // A zero with no count so far is the command itself.
            if (key >= CH_ZERO && key <= CH_NINE && (key != CH_ZERO || cnt != 0)) begin
                cnt = cnt * CNT_W'(10) + CNT_W'(key[3:0]);
                if (on_motion) begin
                    mot_rep = cnt;
                end else begin
                    cmd_rep = cnt;
                end
                return;
            end
            if (on_motion) begin
                mot_ch = key[CH_W-1:0];
            end else begin
                cmd_ch = key[CH_W-1:0];
            end
            if (key == CH_LOW_G || key == CH_LBRACK) begin
                stage = ST_DBL;
            end else begin
                finish_double();
            end
        endfunction

        function void note_key(logic [KEY_W-1:0] key, logic esc);
            t_result r;
            r = '0;
            if (insert_on) begin
                if (esc) begin
                    insert_on = 1'b0;
                    r.kind = KIND_INSERT_END;
                end else begin
                    r.kind = KIND_INSERTED;
                    r.passed_key = key;
                end
                pending_results.push_back(r);
            end else if (esc) begin
                clear_command();
            end else begin
                case (stage)
                    ST_BUF1: begin
                        if (key < CH_LOW_A || key > CH_LOW_Z) begin
                            flag_error();
                        end else begin
                            reg_name = key[CH_W-1:0];
                            stage = ST_CMD;
                            on_motion = 1'b0;
                        end
                    end
                    ST_CMD: begin
                        take_command(key);
                    end
                    ST_DBL: begin
                        if (key != active_char()) begin
                            flag_error();
                        end else begin
                            finish_double();
                        end
                    end
                    ST_ARG: begin
                        // The argument has to fit in seven bits.
                        if (|key[KEY_W-1:CH_W]) begin
                            flag_error();
                        end else begin
                            if (on_motion) begin
                                mot_arg_ch = key[CH_W-1:0];
                            end else begin
                                cmd_arg_ch = key[CH_W-1:0];
                            end
                            finish_argument();
                        end
                    end
                    default: begin
                        if (key == CH_DQUOTE) begin
                            stage = ST_BUF1;
                        end else begin
                            stage = ST_CMD;
                            on_motion = 1'b0;
                            take_command(key);
                        end
                    end
                endcase
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] have);
            if (have !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, have);
                mismatches++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result of kind %0d arrived with nothing expected", got.kind);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("register_letter", 32'(want.reg_letter), 32'(got.reg_letter));
            compare_field("cmd_count", 32'(want.cmd_count), 32'(got.cmd_count));
            compare_field("cmd_char", 32'(want.cmd_char), 32'(got.cmd_char));
            compare_field("cmd_argument", 32'(want.cmd_arg), 32'(got.cmd_arg));
            compare_field("motion_count", 32'(want.mot_count), 32'(got.mot_count));
            compare_field("motion_char", 32'(want.mot_char), 32'(got.mot_char));
            compare_field("motion_argument", 32'(want.mot_arg), 32'(got.mot_arg));
            compare_field("passed_key", 32'(want.passed_key), 32'(got.passed_key));
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_top.sv =====
module tb_top;

    import mkcp_pkg::*;
    import parse_scoreboard_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [KEY_W-1:0]  i_key = '0;
    logic              i_is_escape = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [1:0]        o_kind;
    logic [CH_W-1:0]   o_register_letter;
    logic [CNT_W-1:0]  o_cmd_count;
    logic [CH_W-1:0]   o_cmd_char;
    logic [CH_W-1:0]   o_cmd_argument;
    logic [CNT_W-1:0]  o_motion_count;
    logic [CH_W-1:0]   o_motion_char;
    logic [CH_W-1:0]   o_motion_argument;
    logic [KEY_W-1:0]  o_passed_key;

    int unsigned       send_idle = 34;
    int unsigned       recv_idle = 86;
    bit                rx_hold = 1'b0;
    int unsigned       keys_sent = 0;

    parse_scoreboard   sb = new();

    modal_key_command_parser dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_key             (i_key),
        .i_is_escape       (i_is_escape),
        .empty             (empty),
        .pop               (pop),
        .o_kind            (o_kind),
        .o_register_letter (o_register_letter),
        .o_cmd_count       (o_cmd_count),
        .o_cmd_char        (o_cmd_char),
        .o_cmd_argument    (o_cmd_argument),
        .o_motion_count    (o_motion_count),
        .o_motion_char     (o_motion_char),
        .o_motion_argument (o_motion_argument),
        .o_passed_key      (o_passed_key)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // Handshake values read right after an edge are the ones the block saw at it.
    task automatic send_key(input logic [KEY_W-1:0] key, input logic esc);
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_key <= key;
        i_is_escape <= esc;
        @(posedge i_clk);
        while (full) begin
            @(posedge i_clk);
        end
        sb.note_key(key, esc);
        keys_sent++;
    endtask

    task automatic wait_for_results();
        push <= 1'b0;
        while (sb.pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    function automatic logic [CH_W-1:0] pick_char();
        case ($urandom_range(9))
            0, 1:    return CH_LOW_D;
            2:       return CH_LOW_G;
            3:       return CH_LBRACK;
            4:       return CH_LOW_M;
            5:       return CH_SQUOTE;
            6:       return CH_LOW_I;
            7:       return CH_ZERO;
            default: return CH_W'($urandom_range(CH_TILDE, 'h21));
        endcase
    endfunction

    task automatic send_count();
        int n;
        n = ($urandom_range(7) == 0) ? $urandom_range(5, 7) : $urandom_range(1, 3);
        send_key(KEY_W'(CH_ZERO + $urandom_range(1, 9)), 1'b0);
        repeat (n - 1) send_key(KEY_W'(CH_ZERO + $urandom_range(0, 9)), 1'b0);
    endtask

    // Doubled character or argument; now and then a wrong one.
    task automatic send_tail(input logic [CH_W-1:0] ch);
        if (ch == CH_LOW_G || ch == CH_LBRACK) begin
            send_key(KEY_W'(($urandom_range(9) == 0) ? $urandom_range(127) : ch), 1'b0);
        end
        if (ch == CH_LOW_M || ch == CH_SQUOTE) begin
            send_key(KEY_W'(($urandom_range(9) == 0) ? $urandom : $urandom_range(127)),
                     1'b0);
        end
    endtask

    task automatic send_command();
        logic [CH_W-1:0] ch;
        int              n;
        if ($urandom_range(4) == 0) begin
            send_key(KEY_W'(CH_DQUOTE), 1'b0);
            send_key(KEY_W'(CH_LOW_A + $urandom_range(25)), 1'b0);
        end
        if ($urandom_range(1)) begin
            send_count();
        end
        ch = pick_char();
        send_key(KEY_W'(ch), 1'b0);
        send_tail(ch);
        if (ch == CH_LOW_D) begin
            if ($urandom_range(1)) begin
                send_count();
            end
            ch = pick_char();
            send_key(KEY_W'(ch), 1'b0);
            send_tail(ch);
        end else if (ch == CH_LOW_I) begin
            n = $urandom_range(1, 8);
            repeat (n) begin
                send_key(KEY_W'(($urandom_range(3) == 0) ? $urandom_range(127) : $urandom),
                         1'b0);
            end
            send_key(KEY_W'($urandom), 1'b1);
        end
    endtask

    task automatic random_phase(input int unsigned goal);
        while (keys_sent < goal) begin
            if ($urandom_range(99) < 12) begin
                send_key(KEY_W'(($urandom_range(1) != 0) ? $urandom : $urandom_range(127)),
                         $urandom_range(7) == 0);
            end else begin
                send_command();
            end
        end
    endtask

    // Result side: one transaction per edge at most.
    initial begin
        t_result got;
        wait (i_rst_n);
        forever begin
            if (rx_hold) begin
                pop <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle);
                @(posedge i_clk);
                if (pop && !empty) begin
                    got.kind = t_kind'(o_kind);
                    got.reg_letter = o_register_letter;
                    got.cmd_count = o_cmd_count;
                    got.cmd_char = o_cmd_char;
                    got.cmd_arg = o_cmd_argument;
                    got.mot_count = o_motion_count;
                    got.mot_char = o_motion_char;
                    got.mot_arg = o_motion_argument;
                    got.passed_key = o_passed_key;
                    sb.check_result(got);
                end
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Escape while parsing commands clears quietly, whatever the key bits.
        send_key('1, 1'b1);
        // A lone zero is a command of its own.
        send_key(KEY_W'(CH_ZERO), 1'b0);
        // Named register, a count that wraps past 16 bits, delete with a zero motion.
        send_key(KEY_W'(CH_DQUOTE), 1'b0);
        send_key(KEY_W'(CH_LOW_Z), 1'b0);
        send_key(KEY_W'(CH_ZERO + 6), 1'b0);
        send_key(KEY_W'(CH_ZERO + 5), 1'b0);
        send_key(KEY_W'(CH_ZERO + 5), 1'b0);
        send_key(KEY_W'(CH_ZERO + 3), 1'b0);
        send_key(KEY_W'(CH_ZERO + 7), 1'b0);
        send_key(KEY_W'(CH_LOW_D), 1'b0);
        send_key(KEY_W'(CH_ZERO), 1'b0);
        // Register name just past the letters.
        send_key(KEY_W'(CH_DQUOTE), 1'b0);
        send_key(KEY_W'(CH_LOW_Z + 1), 1'b0);
        // Keys above the printable range where a command is due.
        send_key('1, 1'b0);
        send_key(KEY_W'(CH_TILDE + 1), 1'b0);
        // Doubled command with the wrong second key.
        send_key(KEY_W'(CH_LBRACK), 1'b0);
        send_key(KEY_W'("x"), 1'b0);
        // Arguments just past and right at the seven-bit limit.
        send_key(KEY_W'(CH_LOW_M), 1'b0);
        send_key(KEY_W'(128), 1'b0);
        send_key(KEY_W'(CH_SQUOTE), 1'b0);
        send_key(KEY_W'(127), 1'b0);
        // A delete whose motion is a delete completes as it stands.
        send_key(KEY_W'(CH_LOW_D), 1'b0);
        send_key(KEY_W'(CH_LOW_D), 1'b0);
        // Insert mode passes keys through until escape.
        send_key(KEY_W'(CH_LOW_I), 1'b0);
        send_key('1, 1'b0);
        send_key('0, 1'b0);
        send_key('0, 1'b1);

        // Keep the result side stalled while insert keys pile up behind it.
        rx_hold = 1'b1;
        send_key(KEY_W'(CH_LOW_I), 1'b0);
        repeat (24) send_key(KEY_W'($urandom), 1'b0);
        send_key(KEY_W'($urandom), 1'b1);
        wait_for_results();

        random_phase(keys_sent + 170);
        wait_for_results();

        send_idle = 86;
        recv_idle = 34;
        random_phase(keys_sent + 160);
        wait_for_results();

        send_idle = 0;
        recv_idle = 0;
        random_phase(keys_sent + 160);
        wait_for_results();

        if (sb.pending_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.pending_results.size());
        end
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/mkcp_pkg.sv
hw/rtl/mkcp_front.sv
hw/rtl/mkcp_queue.sv
hw/rtl/mkcp_back.sv
hw/rtl/modal_key_command_parser.sv
tb/sv/parse_scoreboard_pkg.sv
tb/sv/tb_top.sv
